// ===== sv/ppls_pkg.sv =====
// Package for the Phong point-light shader: field widths, item types,
// register map and pipeline depths. No dependencies.
package ppls_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned UNIT_W    = 16;
  localparam int unsigned UNIT_FRAC = 14;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned INTEN_W   = 16;
  localparam int unsigned SHADE_W   = 16;

  localparam int unsigned SUM_W       = 2 * MAG_W + 2;
  localparam int unsigned RAD_W       = SUM_W + 16;
  localparam int unsigned ROOT_W      = RAD_W / 2;
  localparam int unsigned SQRT_STAGES = ROOT_W;
  localparam int unsigned FRAC_SHIFT  = UNIT_FRAC + 8;
  localparam int unsigned DVD_W       = MAG_W + FRAC_SHIFT + 1;
  localparam int unsigned QUO_W       = 15;
  localparam int unsigned DIV_STAGES  = QUO_W;
  localparam int unsigned UV_LAT      = SQRT_STAGES + DIV_STAGES + 4;
  localparam int unsigned TAIL_STAGES = 9;
  localparam int unsigned PIPE_DEPTH  = UV_LAT + TAIL_STAGES + 1;

  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned RGB_W     = 3 * INTEN_W;

  localparam logic [REG_IDX_W-1:0] REG_AMBIENT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIFFUSE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPECULAR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_X  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_Y  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_Z  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_RGB = 3'd6;

  localparam logic [COEF_W-1:0]  AMBIENT_RST  = 16'd6554;
  localparam logic [COEF_W-1:0]  DIFFUSE_RST  = 16'd39322;
  localparam logic [COEF_W-1:0]  SPECULAR_RST = 16'd19661;
  localparam logic [COORD_W-1:0] LIGHT_X_RST  = 16'h0200;
  localparam logic [COORD_W-1:0] LIGHT_Y_RST  = 16'hF600;
  localparam logic [COORD_W-1:0] LIGHT_Z_RST  = 16'hF600;
  localparam logic [RGB_W-1:0]   LIGHT_RGB_RST = 48'h0000_0000_5000;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef struct packed {
    logic [COLOR_W-1:0]        color_r;
    logic [COLOR_W-1:0]        color_g;
    logic [COLOR_W-1:0]        color_b;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [UNIT_W-1:0]  normal_x;
    logic signed [UNIT_W-1:0]  normal_y;
    logic signed [UNIT_W-1:0]  normal_z;
  } frag_t;

  typedef struct packed {
    logic [SHADE_W-1:0] shade_r;
    logic [SHADE_W-1:0] shade_g;
    logic [SHADE_W-1:0] shade_b;
  } shade_t;

endpackage

// ===== sv/ppls_stream_if.sv =====
// Valid/ready stream channel carrying one item of type T.
// No dependencies; the payload type is set where the channel is built.
interface ppls_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/phong_point_light_shader_core.sv =====
// Phong shading core, one point light, eye at the origin.
// Uses ppls_pkg, ppls_stream_if and ppls_unit_vec.
//
// Takes one fragment per clock while the output is taken and returns one shade
// per fragment, in order. Its depth is mostly the 25-stage square root and the
// 15-stage divider that normalize the light and view directions, one result
// bit per stage. The whole pipeline holds while a finished shade waits on the
// output. Registers sit on an APB port at byte address 8*index; write them only
// while no fragment is in flight.
module phong_point_light_shader_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ppls_stream_if.sink                   frag_i,
  ppls_stream_if.source                 shade_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppls_pkg::ADDR_W-1:0]   paddr,
  input  logic [ppls_pkg::DATA_W-1:0]   pwdata,
  output logic [ppls_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import ppls_pkg::*;

  localparam int unsigned NDOT_W = 2 * UNIT_W + 2;
  localparam int unsigned COS_W  = NDOT_W - UNIT_FRAC;
  localparam int unsigned COSD_W = COS_W - 1;
  localparam int unsigned RP_W   = COS_W + UNIT_W;
  localparam int unsigned R_W    = 24;
  localparam int unsigned RV_W   = R_W + UNIT_W;
  localparam int unsigned RDOT_W = RV_W + 2;
  localparam int unsigned S_W    = RDOT_W - 1 - UNIT_FRAC;
  localparam int unsigned SS_W   = 2 * S_W;
  localparam int unsigned S2_W   = SS_W - UNIT_FRAC;
  localparam int unsigned AMB_W  = 2 * COEF_W - 20;
  localparam int unsigned AI_W   = 2 * INTEN_W;
  localparam int unsigned DP_W   = AI_W - UNIT_FRAC + COSD_W;
  localparam int unsigned DIF_W  = DP_W - 16;
  localparam int unsigned SPP_W  = COEF_W + S2_W;
  localparam int unsigned TOT_W  = SPP_W - UNIT_FRAC + 1;
  localparam int signed   UNIT_LIM = 16385;

  typedef struct packed {
    logic [2:0][UNIT_W-1:0]  n;
    logic [2:0][COLOR_W-1:0] c;
  } side_t;

  // configuration
  logic [COEF_W-1:0]  ambient_q, diffuse_q, specular_q;
  logic [COORD_W-1:0] light_x_q, light_y_q, light_z_q;
  logic [RGB_W-1:0]   light_rgb_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ambient_q   <= AMBIENT_RST;
      diffuse_q   <= DIFFUSE_RST;
      specular_q  <= SPECULAR_RST;
      light_x_q   <= LIGHT_X_RST;
      light_y_q   <= LIGHT_Y_RST;
      light_z_q   <= LIGHT_Z_RST;
      light_rgb_q <= LIGHT_RGB_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_AMBIENT:   ambient_q   <= pwdata[COEF_W-1:0];
        REG_DIFFUSE:   diffuse_q   <= pwdata[COEF_W-1:0];
        REG_SPECULAR:  specular_q  <= pwdata[COEF_W-1:0];
        REG_LIGHT_X:   light_x_q   <= pwdata[COORD_W-1:0];
        REG_LIGHT_Y:   light_y_q   <= pwdata[COORD_W-1:0];
        REG_LIGHT_Z:   light_z_q   <= pwdata[COORD_W-1:0];
        REG_LIGHT_RGB: light_rgb_q <= pwdata[RGB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_AMBIENT:   prdata = DATA_W'(ambient_q);
      REG_DIFFUSE:   prdata = DATA_W'(diffuse_q);
      REG_SPECULAR:  prdata = DATA_W'(specular_q);
      REG_LIGHT_X:   prdata = DATA_W'(light_x_q);
      REG_LIGHT_Y:   prdata = DATA_W'(light_y_q);
      REG_LIGHT_Z:   prdata = DATA_W'(light_z_q);
      REG_LIGHT_RGB: prdata = DATA_W'(light_rgb_q);
      default:       prdata = '0;
    endcase
  end

  logic [INTEN_W-1:0] inten [3];
  assign inten[0] = light_rgb_q[3*INTEN_W-1:2*INTEN_W];
  assign inten[1] = light_rgb_q[2*INTEN_W-1:INTEN_W];
  assign inten[2] = light_rgb_q[INTEN_W-1:0];

  // pipeline control
  logic [PIPE_DEPTH-1:0] vld_q;
  logic adv;

  assign adv          = !vld_q[PIPE_DEPTH-1] || shade_o.ready;
  assign frag_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], frag_i.valid};
    end
  end

  // front: direction vectors
  diff_t dl_q [3];
  diff_t dv_q [3];
  side_t fs_q;
  logic signed [COORD_W-1:0] lp_w [3];
  logic signed [COORD_W-1:0] p_w  [3];

  assign lp_w[0] = $signed(light_x_q);
  assign lp_w[1] = $signed(light_y_q);
  assign lp_w[2] = $signed(light_z_q);
  assign p_w[0]  = frag_i.data.pos_x;
  assign p_w[1]  = frag_i.data.pos_y;
  assign p_w[2]  = frag_i.data.pos_z;

  for (genvar i = 0; i < 3; i++) begin : g_front
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dl_q[i] <= DIFF_W'(lp_w[i]) - DIFF_W'(p_w[i]);
        dv_q[i] <= -DIFF_W'(p_w[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fs_q.n <= {frag_i.data.normal_z, frag_i.data.normal_y, frag_i.data.normal_x};
      fs_q.c <= {frag_i.data.color_b, frag_i.data.color_g, frag_i.data.color_r};
    end
  end

  unit_t l_w [3];
  unit_t v_w [3];

  ppls_unit_vec u_light (
    .clk_i  (clk_i),
    .en_i   (adv),
    .dir_i  (dl_q),
    .unit_o (l_w)
  );

  ppls_unit_vec u_view (
    .clk_i  (clk_i),
    .en_i   (adv),
    .dir_i  (dv_q),
    .unit_o (v_w)
  );

  side_t side_q [UV_LAT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= fs_q;
    end
  end

  for (genvar k = 1; k < UV_LAT; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // tail stage 1: N.L products, color products
  logic signed [2*UNIT_W-1:0] nl1_q [3];
  logic [2*COEF_W-1:0] amb1_q [3], adp1_q [3];
  unit_t l1_q [3], v1_q [3], n1_q [3];

  // stage 2
  logic signed [NDOT_W-1:0] ndotl_w;
  logic signed [COS_W-1:0]  cos2_q;
  logic [COSD_W-1:0]        cosd2_q;
  logic [AI_W-1:0]          ai2_q [3];
  logic [AMB_W-1:0]         amb2_q [3];
  unit_t l2_q [3], v2_q [3], n2_q [3];

  // stage 3
  logic signed [RP_W-1:0] rp3_q [3];
  logic [DP_W-1:0]        dp3_q [3];
  logic [AMB_W-1:0]       amb3_q [3];
  unit_t l3_q [3], v3_q [3];

  // stage 4
  logic signed [R_W-1:0] r4_q [3];
  logic [DIF_W-1:0]      dif4_q [3];
  logic [COEF_W-1:0]     ksi4_q [3];
  logic [AMB_W-1:0]      amb4_q [3];
  unit_t v4_q [3];
  logic [2*COEF_W-1:0]   ksi_w [3];

  // stage 5
  logic signed [RV_W-1:0] rv5_q [3];
  logic [DIF_W-1:0]  dif5_q [3];
  logic [COEF_W-1:0] ksi5_q [3];
  logic [AMB_W-1:0]  amb5_q [3];

  // stage 6
  logic signed [RDOT_W-1:0] rdotv_w;
  logic [S_W-1:0]    s6_q;
  logic [DIF_W-1:0]  dif6_q [3];
  logic [COEF_W-1:0] ksi6_q [3];
  logic [AMB_W-1:0]  amb6_q [3];

  // stage 7
  logic [SS_W-1:0]   ss7_q;
  logic [DIF_W-1:0]  dif7_q [3];
  logic [COEF_W-1:0] ksi7_q [3];
  logic [AMB_W-1:0]  amb7_q [3];

  // stage 8
  logic [SPP_W-1:0]  spp8_q [3];
  logic [DIF_W-1:0]  dif8_q [3];
  logic [AMB_W-1:0]  amb8_q [3];

  // stage 9
  logic [TOT_W-1:0]   tot_w [3];
  logic [SHADE_W-1:0] shade_q [3];

  assign ndotl_w = NDOT_W'(nl1_q[0]) + NDOT_W'(nl1_q[1]) + NDOT_W'(nl1_q[2]);
  assign rdotv_w = RDOT_W'(rv5_q[0]) + RDOT_W'(rv5_q[1]) + RDOT_W'(rv5_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cos2_q  <= ndotl_w[NDOT_W-1:UNIT_FRAC];
      cosd2_q <= (ndotl_w > 0) ? ndotl_w[NDOT_W-2:UNIT_FRAC] : '0;
      s6_q    <= (rdotv_w > 0) ? rdotv_w[RDOT_W-2:UNIT_FRAC] : '0;
      ss7_q   <= SS_W'(s6_q) * SS_W'(s6_q);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_tail
    logic [2*COLOR_W-1:0] c16;
    assign c16      = {side_q[UV_LAT-1].c[i], side_q[UV_LAT-1].c[i]};
    assign ksi_w[i] = specular_q * inten[i];
    assign tot_w[i] = TOT_W'(amb8_q[i]) + TOT_W'(dif8_q[i])
                    + TOT_W'(spp8_q[i][SPP_W-1:UNIT_FRAC]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        nl1_q[i]  <= l_w[i] * $signed(side_q[UV_LAT-1].n[i]);
        amb1_q[i] <= ambient_q * c16;
        adp1_q[i] <= diffuse_q * c16;
        l1_q[i]   <= l_w[i];
        v1_q[i]   <= v_w[i];
        n1_q[i]   <= $signed(side_q[UV_LAT-1].n[i]);

        ai2_q[i]  <= adp1_q[i][2*COEF_W-1:COEF_W] * inten[i];
        amb2_q[i] <= amb1_q[i][2*COEF_W-1:20];
        l2_q[i]   <= l1_q[i];
        v2_q[i]   <= v1_q[i];
        n2_q[i]   <= n1_q[i];

        rp3_q[i]  <= cos2_q * n2_q[i];
        dp3_q[i]  <= DP_W'(ai2_q[i][AI_W-1:UNIT_FRAC]) * DP_W'(cosd2_q);
        amb3_q[i] <= amb2_q[i];
        l3_q[i]   <= l2_q[i];
        v3_q[i]   <= v2_q[i];

        // floor(2*cos*n / 2^14) - L
        r4_q[i]   <= R_W'($signed(rp3_q[i][RP_W-1:UNIT_FRAC-1])) - R_W'(l3_q[i]);
        dif4_q[i] <= dp3_q[i][DP_W-1:16];
        ksi4_q[i] <= ksi_w[i][2*COEF_W-1:COEF_W];
        amb4_q[i] <= amb3_q[i];
        v4_q[i]   <= v3_q[i];

        rv5_q[i]  <= r4_q[i] * v4_q[i];
        dif5_q[i] <= dif4_q[i];
        ksi5_q[i] <= ksi4_q[i];
        amb5_q[i] <= amb4_q[i];

        dif6_q[i] <= dif5_q[i];
        ksi6_q[i] <= ksi5_q[i];
        amb6_q[i] <= amb5_q[i];

        dif7_q[i] <= dif6_q[i];
        ksi7_q[i] <= ksi6_q[i];
        amb7_q[i] <= amb6_q[i];

        spp8_q[i] <= SPP_W'(ksi7_q[i]) * SPP_W'(ss7_q[SS_W-1:UNIT_FRAC]);
        dif8_q[i] <= dif7_q[i];
        amb8_q[i] <= amb7_q[i];

        shade_q[i] <= (tot_w[i] > TOT_W'({SHADE_W{1'b1}})) ? {SHADE_W{1'b1}}
                                                          : tot_w[i][SHADE_W-1:0];
      end
    end
  end

  assign shade_o.valid        = vld_q[PIPE_DEPTH-1];
  assign shade_o.data.shade_r = shade_q[0];
  assign shade_o.data.shade_g = shade_q[1];
  assign shade_o.data.shade_b = shade_q[2];

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> vld_q == $past(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_light_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[UV_LAT] |-> (l_w[0] <= UNIT_LIM && l_w[0] >= -UNIT_LIM &&
                       l_w[1] <= UNIT_LIM && l_w[1] >= -UNIT_LIM &&
                       l_w[2] <= UNIT_LIM && l_w[2] >= -UNIT_LIM))
    else $error("light direction component out of unit range");

  a_view_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[UV_LAT] |-> (v_w[0] <= UNIT_LIM && v_w[0] >= -UNIT_LIM &&
                       v_w[1] <= UNIT_LIM && v_w[1] >= -UNIT_LIM &&
                       v_w[2] <= UNIT_LIM && v_w[2] >= -UNIT_LIM))
    else $error("view direction component out of unit range");

  a_cosd_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[UV_LAT+2] |-> (cosd2_q == '0 || !cos2_q[COS_W-1]))
    else $error("diffuse cosine nonzero for a back-facing light");
`endif

endmodule

// ===== sv/ppls_unit_vec.sv =====
// Pipelined normalizer: direction vector to unit vector in Q2.14.
// Squares, bit-per-stage square root, bit-per-stage divide. Uses ppls_pkg.
module ppls_unit_vec (
  input  logic            clk_i,
  input  logic            en_i,
  input  ppls_pkg::diff_t dir_i  [3],
  output ppls_pkg::unit_t unit_o [3]
);
  import ppls_pkg::*;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  zero;
  } side_t;

  logic signed [2*DIFF_W-1:0] sq_w [3];
  logic [MAG_W-1:0]   mag_w [3];
  logic [2*MAG_W-1:0] sqr_q [3];
  logic [MAG_W-1:0]   mag_q [3];
  logic [2:0]         neg_q;
  logic [SUM_W-1:0]   sum_w;

  logic [RAD_W-1:0]  rem_q  [SQRT_STAGES+1];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES+1];
  side_t             sd_q   [SQRT_STAGES+1];

  logic [DVD_W-1:0]  drem_q [DIV_STAGES+1][3];
  logic [QUO_W-1:0]  quo_q  [DIV_STAGES+1][3];
  logic [ROOT_W-1:0] len_q  [DIV_STAGES+1];
  logic [2:0]        dneg_q [DIV_STAGES+1];
  logic              dzero_q[DIV_STAGES+1];

  unit_t unit_q [3];

  // squares and magnitudes
  for (genvar i = 0; i < 3; i++) begin : g_sq
    assign sq_w[i]  = dir_i[i] * dir_i[i];
    assign mag_w[i] = dir_i[i][DIFF_W-1] ? MAG_W'(-dir_i[i]) : MAG_W'(dir_i[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sqr_q[i] <= sq_w[i][2*MAG_W-1:0];
        mag_q[i] <= mag_w[i];
        neg_q[i] <= dir_i[i][DIFF_W-1];
      end
    end
  end

  assign sum_w = SUM_W'(sqr_q[0]) + SUM_W'(sqr_q[1]) + SUM_W'(sqr_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]       <= {sum_w, 16'd0};
      root_q[0]      <= '0;
      sd_q[0].mag    <= {mag_q[2], mag_q[1], mag_q[0]};
      sd_q[0].neg    <= neg_q;
      sd_q[0].zero   <= (sum_w == '0);
    end
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    localparam int unsigned K = SQRT_STAGES - 1 - j;
    logic [RAD_W+1:0] trial;
    logic             fit;
    assign trial = ((RAD_W+2)'(root_q[j]) << (K + 1)) | ((RAD_W+2)'(1) << (2 * K));
    assign fit   = {2'b00, rem_q[j]} >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= fit ? RAD_W'({2'b00, rem_q[j]} - trial) : rem_q[j];
        root_q[j+1] <= fit ? (root_q[j] | (ROOT_W'(1) << K)) : root_q[j];
        sd_q[j+1]   <= sd_q[j];
      end
    end
  end

  // dividend with rounding term
  for (genvar i = 0; i < 3; i++) begin : g_prep
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[0][i] <= DVD_W'({sd_q[SQRT_STAGES].mag[i], FRAC_SHIFT'(0)})
                      + DVD_W'(root_q[SQRT_STAGES] >> 1);
        quo_q[0][i]  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q[0]   <= root_q[SQRT_STAGES];
      dneg_q[0]  <= sd_q[SQRT_STAGES].neg;
      dzero_q[0] <= sd_q[SQRT_STAGES].zero;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int unsigned K = DIV_STAGES - 1 - j;
    logic [DVD_W:0] dsr;
    assign dsr = (DVD_W+1)'(len_q[j]) << K;
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic fit;
      assign fit = {1'b0, drem_q[j][i]} >= dsr;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          drem_q[j+1][i] <= fit ? DVD_W'({1'b0, drem_q[j][i]} - dsr) : drem_q[j][i];
          quo_q[j+1][i]  <= fit ? (quo_q[j][i] | (QUO_W'(1) << K)) : quo_q[j][i];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[j+1]   <= len_q[j];
        dneg_q[j+1]  <= dneg_q[j];
        dzero_q[j+1] <= dzero_q[j];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sign
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (dzero_q[DIV_STAGES]) begin
          unit_q[i] <= '0;
        end else if (dneg_q[DIV_STAGES][i]) begin
          unit_q[i] <= -$signed({1'b0, quo_q[DIV_STAGES][i]});
        end else begin
          unit_q[i] <= $signed({1'b0, quo_q[DIV_STAGES][i]});
        end
      end
    end
    assign unit_o[i] = unit_q[i];
  end

endmodule

// ===== verif/ppls_checker.sv =====
// Shade checker for the Phong point-light core: watches the fragment and shade channels,
// predicts each shade from the register copy and compares. Uses ppls_pkg.
module ppls_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic frag_valid_i,
  input  logic frag_ready_i,
  input  ppls_pkg::frag_t frag_i,
  input  logic shade_valid_i,
  input  logic shade_ready_i,
  input  ppls_pkg::shade_t shade_i,
  input  logic cfg_we_i,
  input  logic [ppls_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppls_pkg::DATA_W-1:0] cfg_data_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppls_pkg::*;

  logic [15:0] ka, kd, ks;
  logic signed [15:0] lx, ly, lz;
  logic [47:0] lrgb;
  shade_t shade_q[$];

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint fdiv14(longint x);
    if (x >= 0) return x >>> 14;
    return -((-x + 16383) >>> 14);
  endfunction

  function automatic void normalize(input longint d[3], output longint u[3]);
    longint unsigned sq, len, mag;
    longint q;
    sq = 0;
    for (int i = 0; i < 3; i++) sq += d[i] * d[i];
    if (sq == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    len = root64(sq << 16);
    for (int i = 0; i < 3; i++) begin
      mag = (d[i] < 0) ? -d[i] : d[i];
      q = ((mag << 22) + len / 2) / len;
      u[i] = (d[i] < 0) ? -q : q;
    end
  endfunction

  function automatic shade_t predict_shade(frag_t f);
    longint pt[3], nm[3], dl[3], dv[3], lu[3], vu[3], rf[3], lp[3];
    longint ndotl, rdotv, c14;
    longint unsigned cosd, sp, sp2, c16, inten, amb, a, dif, spc, sum;
    logic [7:0] col[3];
    logic [15:0] res[3];
    shade_t o;
    lp = '{lx, ly, lz};
    pt = '{f.pos_x, f.pos_y, f.pos_z};
    nm = '{f.normal_x, f.normal_y, f.normal_z};
    col = '{f.color_r, f.color_g, f.color_b};
    for (int i = 0; i < 3; i++) begin
      dl[i] = lp[i] - pt[i];
      dv[i] = -pt[i];
    end
    normalize(dl, lu);
    normalize(dv, vu);
    ndotl = 0;
    for (int i = 0; i < 3; i++) ndotl += nm[i] * lu[i];
    cosd = (ndotl > 0) ? (ndotl >> 14) : 0;
    c14 = fdiv14(ndotl);
    for (int i = 0; i < 3; i++) rf[i] = fdiv14(2 * c14 * nm[i]) - lu[i];
    rdotv = 0;
    for (int i = 0; i < 3; i++) rdotv += rf[i] * vu[i];
    sp = (rdotv > 0) ? (rdotv >> 14) : 0;
    sp2 = (sp * sp) >> 14;
    for (int i = 0; i < 3; i++) begin
      c16 = col[i] * 257;
      inten = (lrgb >> (32 - 16 * i)) & 48'hFFFF;
      amb = (ka * c16) >> 20;
      a = (kd * c16) >> 16;
      dif = (((a * inten) >> 14) * cosd) >> 16;
      spc = (((ks * inten) >> 16) * sp2) >> 14;
      sum = amb + dif + spc;
      res[i] = (sum > 65535) ? 16'hFFFF : sum[15:0];
    end
    o.shade_r = res[0];
    o.shade_g = res[1];
    o.shade_b = res[2];
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    shade_t exp_s;
    if (!rst_ni) begin
      ka <= AMBIENT_RST;
      kd <= DIFFUSE_RST;
      ks <= SPECULAR_RST;
      lx <= LIGHT_X_RST;
      ly <= LIGHT_Y_RST;
      lz <= LIGHT_Z_RST;
      lrgb <= LIGHT_RGB_RST;
      errors_o <= 0;
      pending_o <= 0;
      shade_q.delete();
    end else begin
      if (frag_valid_i && frag_ready_i) shade_q.push_back(predict_shade(frag_i));
      if (shade_valid_i && shade_ready_i) begin
        if (shade_q.size() == 0) begin
          $display("%t unexpected shade: actual %h", $realtime, shade_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_s = shade_q.pop_front();
          if (exp_s.shade_r !== shade_i.shade_r || exp_s.shade_g !== shade_i.shade_g ||
              exp_s.shade_b !== shade_i.shade_b) begin
            $display("%t shade mismatch: expected %h actual %h", $realtime, exp_s, shade_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= shade_q.size();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_AMBIENT:   ka <= cfg_data_i[15:0];
          REG_DIFFUSE:   kd <= cfg_data_i[15:0];
          REG_SPECULAR:  ks <= cfg_data_i[15:0];
          REG_LIGHT_X:   lx <= cfg_data_i[15:0];
          REG_LIGHT_Y:   ly <= cfg_data_i[15:0];
          REG_LIGHT_Z:   lz <= cfg_data_i[15:0];
          REG_LIGHT_RGB: lrgb <= cfg_data_i[47:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== verif/testbench.sv =====
// Top of the Phong point-light shader bench: clock, reset, APB register writes,
// fragment stimulus and verdict. Uses ppls_pkg, ppls_stream_if, ppls_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ppls_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic shade_rdy_en = 1'b0;
  int unsigned errors, pending;

  ppls_stream_if #(frag_t) frag_ch ();
  ppls_stream_if #(shade_t) shade_ch ();

  initial begin
    frag_ch.valid = 1'b0;
    frag_ch.data = '0;
    shade_ch.ready = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  phong_point_light_shader_core i_dut (
    .clk_i, .rst_ni, .frag_i(frag_ch.sink), .shade_o(shade_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ppls_checker i_checker (
    .clk_i, .rst_ni,
    .frag_valid_i(frag_ch.valid), .frag_ready_i(frag_ch.ready), .frag_i(frag_ch.data),
    .shade_valid_i(shade_ch.valid), .shade_ready_i(shade_ch.ready), .shade_i(shade_ch.data),
    .cfg_we_i(psel && penable && pwrite && pready),
    .cfg_idx_i(paddr[ADDR_W-1:3]), .cfg_data_i(pwdata),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver: random stall per item
  always begin
    int gap;
    if (!shade_rdy_en) begin
      @(posedge clk_i);
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap != 0) begin
        shade_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      shade_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(shade_ch.valid && shade_ch.ready));
    end
  end

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_frag(input frag_t f, input bit no_gap);
    int gap;
    gap = (no_gap || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      frag_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frag_ch.valid <= 1'b1;
    frag_ch.data <= f;
    do @(posedge clk_i); while (!frag_ch.ready);
  endtask

  task automatic drain;
    frag_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_unit();
    case ($urandom_range(0, 3))
      0: return 16'($signed($urandom_range(0, 32768)) - 16384);
      1: return 16'($urandom());
      default: return 16'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic logic [15:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(0, 8192)) - 4096);
      default: return 16'($signed($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  function automatic frag_t rand_frag();
    frag_t f;
    f.color_r = 8'($urandom());
    f.color_g = 8'($urandom());
    f.color_b = 8'($urandom());
    f.pos_x = rand_pos();
    f.pos_y = rand_pos();
    f.pos_z = rand_pos();
    f.normal_x = rand_unit();
    f.normal_y = rand_unit();
    f.normal_z = rand_unit();
    return f;
  endfunction

  task automatic set_all_regs(input bit extreme);
    for (int i = 0; i <= REG_LIGHT_Z; i++)
      reg_write(i[REG_IDX_W-1:0], extreme ? 64'($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                           : 64'($urandom()));
    reg_write(REG_LIGHT_RGB, {$urandom(), $urandom()});
  endtask

  initial begin
    frag_t f;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    shade_rdy_en <= 1'b1;
    @(posedge clk_i);
    // directed
    f = '0;
    send_frag(f, 1);                                  // point at origin
    f = '{8'hFF, 8'hFF, 8'hFF, 16'h0200, 16'hF600, 16'hF600, 16'h4000, 16'h0, 16'h0};
    send_frag(f, 1);                                  // light on the point
    f = '{8'hFF, 8'h00, 8'h80, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hC000, 16'h4000, 16'hC000};
    send_frag(f, 1);
    f = '{8'h00, 8'hFF, 8'h01, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF};
    send_frag(f, 0);
    f = '{8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 16'h0500, 16'h0, 16'h0, 16'hC000};
    send_frag(f, 0);
    drain();
    reg_write(REG_AMBIENT, 64'hFFFF);
    reg_write(REG_DIFFUSE, 64'hFFFF);
    reg_write(REG_SPECULAR, 64'hFFFF);
    reg_write(REG_LIGHT_RGB, 64'hFFFF_FFFF_FFFF_FFFF);
    f = '{8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 16'h0500, 16'h0, 16'h0, 16'hC000};
    send_frag(f, 1);                                  // saturation
    for (int i = 0; i < 10; i++) send_frag(rand_frag(), 0);
    drain();
    // random phases through several register settings
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 1) begin
        for (int i = 0; i <= REG_LIGHT_RGB; i++) reg_write(i[REG_IDX_W-1:0], '0);
      end else begin
        set_all_regs(ph == 4);
      end
      for (int i = 0; i < 85; i++) send_frag(rand_frag(), (ph == 3));
      drain();
    end
    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("status: fail");
    $finish;
  end
endmodule
